### src/assert_macros.svh
// Assertion macros for the RTL; lfhp_parser.sv is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LFHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lfhp assertion failed");

// Check a property on every clock edge, reset included.
`define LFHP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lfhp assertion failed");

`endif

### src/lfhp_pkg.sv
// Package for the LED frame header parser: constants, phase type and result struct.
package lfhp_pkg;

  localparam int MAX_LEDS       = 1024;
  localparam int BYTES_EACH_LED = 3;

  localparam int BYTE_W = 8;
  localparam int LEDS_W = 11;
  localparam int POS_W  = 12;

  localparam logic [BYTE_W-1:0] MAGIC_A  = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] MAGIC_D  = 8'h64;  // 'd'
  localparam logic [BYTE_W-1:0] MAGIC_A2 = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CHK_KEY  = 8'h55;

  localparam logic [LEDS_W-1:0] EXPECTED_LEDS_RESET = 11'd60;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_EXPECTED_LEDS = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT_A,
    PH_WAIT_D,
    PH_WAIT_A2,
    PH_WAIT_HI,
    PH_WAIT_LO,
    PH_WAIT_CHK,
    PH_COLORS
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] color_byte;
    logic [POS_W-1:0]  byte_position;
    logic              frame_end;
  } res_t;

endpackage

### src/lfhp_intf.sv
// Stream interfaces for the received bytes and the colour bytes.
interface lfhp_rx_if;
  import lfhp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfhp_color_if;
  import lfhp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] color_byte;
  logic [POS_W-1:0]  byte_position;
  logic              frame_end;

  modport source (output valid, output color_byte, output byte_position,
                  output frame_end, input ready);
  modport sink (input valid, input color_byte, input byte_position,
                input frame_end, output ready);
endinterface

### src/lfhp_cfg.sv
// APB register block holding the expected LED count.
module lfhp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfhp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lfhp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lfhp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [lfhp_pkg::LEDS_W-1:0]      expected_leds
);
  import lfhp_pkg::*;

  logic hit;

  assign hit    = (paddr[APB_ADDR_W-1:2] == REG_EXPECTED_LEDS);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_leds <= EXPECTED_LEDS_RESET;
    end else if (psel && penable && pwrite && hit) begin
      expected_leds <= pwdata[LEDS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = APB_DATA_W'(expected_leds);
    end
  end

endmodule

### src/lfhp_parser.sv
// Header parser state machine with colour byte counter.
`include "assert_macros.svh"

module lfhp_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [lfhp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [lfhp_pkg::LEDS_W-1:0]  expected_leds,
  output lfhp_pkg::res_t               res,
  output logic                         in_colors
);
  import lfhp_pkg::*;

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  count_high;
  logic [BYTE_W-1:0]  count_low;
  logic [POS_W-1:0]   color_index;
  logic [POS_W-1:0]   frame_bytes;
  logic [13:0]        frame_bytes_calc;
  logic               header_ok;
  logic               last;

  assign frame_bytes_calc = 14'(expected_leds) * 14'(BYTES_EACH_LED);

  assign header_ok = (rx_byte == (count_high ^ count_low ^ CHK_KEY)) &&
                     (({1'b0, count_high, count_low} + 17'd1) == 17'(expected_leds)) &&
                     (expected_leds <= LEDS_W'(MAX_LEDS));

  assign last      = (13'(color_index) + 13'd1) >= 13'(frame_bytes);
  assign in_colors = (phase == PH_COLORS);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT_A:   if (rx_byte == MAGIC_A) phase_next = PH_WAIT_D;
      PH_WAIT_D:   phase_next = (rx_byte == MAGIC_D) ? PH_WAIT_A2 : PH_HUNT_A;
      PH_WAIT_A2:  phase_next = (rx_byte == MAGIC_A2) ? PH_WAIT_HI : PH_HUNT_A;
      PH_WAIT_HI:  phase_next = PH_WAIT_LO;
      PH_WAIT_LO:  phase_next = PH_WAIT_CHK;
      PH_WAIT_CHK: phase_next = header_ok ? PH_COLORS : PH_HUNT_A;
      PH_COLORS:   if (last) phase_next = PH_HUNT_A;
      default:     phase_next = PH_HUNT_A;
    endcase
  end

  always_comb begin
    res               = '0;
    res.valid         = fire && (phase == PH_COLORS);
    res.color_byte    = rx_byte;
    res.byte_position = color_index;
    res.frame_end     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT_A;
      count_high  <= '0;
      count_low   <= '0;
      color_index <= '0;
      frame_bytes <= '0;
    end else if (fire) begin
      phase <= phase_next;
      if (phase == PH_WAIT_HI) begin
        count_high <= rx_byte;
      end
      if (phase == PH_WAIT_LO) begin
        count_low <= rx_byte;
      end
      if (phase == PH_WAIT_CHK && header_ok) begin
        frame_bytes <= frame_bytes_calc[POS_W-1:0];
        color_index <= '0;
      end
      if (phase == PH_COLORS) begin
        color_index <= color_index + POS_W'(1);
      end
    end
  end

  `LFHP_ASSERT(a_index_in_frame, in_colors |-> (color_index < frame_bytes))
  `LFHP_ASSERT(a_end_returns_hunt, (res.valid && res.frame_end) |=> (phase == PH_HUNT_A))
  `LFHP_ASSERT(a_frame_starts_at_zero,
               (fire && phase == PH_WAIT_CHK && header_ok) |=> (color_index == '0 && in_colors))
  `LFHP_ASSERT_ALWAYS(a_reset_hunts, rst |=> (phase == PH_HUNT_A && !res.valid))

endmodule

### src/lfhp_out_stage.sv
// Result register between the parser and the colour stream.
module lfhp_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  lfhp_pkg::res_t       res,
  output logic                 can_take,
  lfhp_color_if.source         color_stream
);
  import lfhp_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] color_byte;
  logic [POS_W-1:0]  byte_position;
  logic              frame_end;

  assign can_take = !valid || color_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid) begin
      valid <= 1'b1;
    end else if (color_stream.ready) begin
      valid <= 1'b0;
    end
  end

  // payload loads only when a new result arrives
  always_ff @(posedge clk) begin
    if (res.valid) begin
      color_byte    <= res.color_byte;
      byte_position <= res.byte_position;
      frame_end     <= res.frame_end;
    end
  end

  assign color_stream.valid         = valid;
  assign color_stream.color_byte    = color_byte;
  assign color_stream.byte_position = byte_position;
  assign color_stream.frame_end     = frame_end;

endmodule

### src/led_frame_header_parser_top.sv
// Top level of the LED frame header parser.
//
//  channel       | direction | transfer carries
//  byte_stream   | sink      | rx_byte
//  color_stream  | source    | color_byte, byte_position, frame_end
//  APB           | slave     | expected_leds at byte address 0
//
// One byte per cycle unless stalled: parser state and counters update in the cycle a
// byte transfers, and a colour result appears on color_stream the cycle after.
// Header bytes are taken even while a colour result waits; colour bytes wait only
// when the result register is full and color_stream is stalled.
// Synchronous reset clears the parser to hunting for 'A' and sets expected_leds to 60.
module led_frame_header_parser_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfhp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lfhp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lfhp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  lfhp_rx_if.sink                          byte_stream,
  lfhp_color_if.source                     color_stream
);
  import lfhp_pkg::*;

  logic [LEDS_W-1:0] expected_leds;
  res_t              res;
  logic              in_colors;
  logic              can_take;
  logic              fire;

  assign byte_stream.ready = can_take || !in_colors;
  assign fire              = byte_stream.valid && byte_stream.ready;

  lfhp_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .expected_leds (expected_leds)
  );

  lfhp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .rx_byte       (byte_stream.rx_byte),
    .expected_leds (expected_leds),
    .res           (res),
    .in_colors     (in_colors)
  );

  lfhp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .can_take     (can_take),
    .color_stream (color_stream)
  );

endmodule

### sim/lfhp_color_checker.sv
// Checker for the LED frame header parser: follows the byte stream, predicts and compares colour transfers.
`timescale 1ns / 1ps
module lfhp_color_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [lfhp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lfhp_pkg::APB_DATA_W-1:0] pwdata,
  lfhp_rx_if                              rx,
  lfhp_color_if                           col,
  output int                              mismatches,
  output int                              colors_checked,
  output int                              colors_due
);
  import lfhp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] color_byte;
    logic [POS_W-1:0]  byte_position;
    logic              frame_end;
  } color_exp_t;

  phase_t            parse_ph;
  logic [BYTE_W-1:0] count_hi;
  logic [BYTE_W-1:0] count_lo;
  logic [LEDS_W-1:0] leds_cfg;
  int                frame_len;
  int                color_idx;
  color_exp_t        due_colors[$];

  // Advance the header parser by one received byte; queue a colour byte when one is due.
  task automatic track_byte(input logic [BYTE_W-1:0] b);
    int         announced;
    color_exp_t e;
    case (parse_ph)
      PH_HUNT_A: begin
        if (b == MAGIC_A) parse_ph = PH_WAIT_D;
      end
      PH_WAIT_D: parse_ph = (b == MAGIC_D) ? PH_WAIT_A2 : PH_HUNT_A;
      PH_WAIT_A2: parse_ph = (b == MAGIC_A2) ? PH_WAIT_HI : PH_HUNT_A;
      PH_WAIT_HI: begin
        count_hi = b;
        parse_ph = PH_WAIT_LO;
      end
      PH_WAIT_LO: begin
        count_lo = b;
        parse_ph = PH_WAIT_CHK;
      end
      PH_WAIT_CHK: begin
        parse_ph  = PH_HUNT_A;
        announced = int'({count_hi, count_lo}) + 1;
        if (b == (count_hi ^ count_lo ^ CHK_KEY) && announced == int'(leds_cfg) &&
            int'(leds_cfg) <= MAX_LEDS) begin
          frame_len = int'(leds_cfg) * BYTES_EACH_LED;
          color_idx = 0;
          parse_ph  = PH_COLORS;
        end
      end
      PH_COLORS: begin
        e.color_byte    = b;
        e.byte_position = color_idx[POS_W-1:0];
        e.frame_end     = (color_idx + 1 >= frame_len);
        due_colors.push_back(e);
        color_idx++;
        if (e.frame_end) parse_ph = PH_HUNT_A;
      end
      default: parse_ph = PH_HUNT_A;
    endcase
  endtask

  always @(posedge clk) begin
    color_exp_t want;
    logic       bad;
    if (rst) begin
      parse_ph  = PH_HUNT_A;
      count_hi  = '0;
      count_lo  = '0;
      leds_cfg  = EXPECTED_LEDS_RESET;
      frame_len = 0;
      color_idx = 0;
      due_colors.delete();
      mismatches     <= 0;
      colors_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_W-1:2] == REG_EXPECTED_LEDS) begin
        leds_cfg = pwdata[LEDS_W-1:0];
      end
      if (rx.valid && rx.ready) track_byte(rx.rx_byte);
      if (col.valid && col.ready) begin
        if (due_colors.size() == 0) begin
          $display("%0t: colour transfer with none due: byte %0d position %0d end %0b",
                   $time, col.color_byte, col.byte_position, col.frame_end);
          mismatches <= mismatches + 1;
        end else begin
          want = due_colors.pop_front();
          bad  = 1'b0;
          if (col.color_byte !== want.color_byte) begin
            $display("%0t: color_byte expected %0d, got %0d",
                     $time, want.color_byte, col.color_byte);
            bad = 1'b1;
          end
          if (col.byte_position !== want.byte_position) begin
            $display("%0t: byte_position expected %0d, got %0d",
                     $time, want.byte_position, col.byte_position);
            bad = 1'b1;
          end
          if (col.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b, got %0b",
                     $time, want.frame_end, col.frame_end);
            bad = 1'b1;
          end
          if (bad) mismatches <= mismatches + 1;
          colors_checked <= colors_checked + 1;
        end
      end
    end
    colors_due <= due_colors.size();
  end

endmodule

### sim/tb_led_frame_header_parser_top.sv
// Testbench top for the LED frame header parser: clock, reset, byte and APB stimulus, verdict.
`timescale 1ns / 1ps
module tb_led_frame_header_parser_top;
  import lfhp_pkg::*;

  localparam int TOTAL_ITEMS   = 1150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_LEDS     = 100;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int   mismatches;
  int   colors_checked;
  int   colors_due;
  int   cur_leds      = int'(EXPECTED_LEDS_RESET);
  int   bytes_sent    = 0;
  int   settings_used = 1;
  logic idle_en       = 1'b1;
  logic hold_off_req  = 1'b0;

  lfhp_rx_if    byte_stream ();
  lfhp_color_if color_stream ();

  led_frame_header_parser_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .byte_stream  (byte_stream),
    .color_stream (color_stream)
  );

  lfhp_color_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .rx             (byte_stream),
    .col            (color_stream),
    .mismatches     (mismatches),
    .colors_checked (colors_checked),
    .colors_due     (colors_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Colour side: random stalls, plus one long hold-off on request.
  initial begin
    color_stream.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        color_stream.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      color_stream.ready <= (!idle_en || $urandom_range(0, 99) >= 10);
    end
  end

  function automatic logic [BYTE_W-1:0] header_sum(input logic [15:0] count);
    return count[15:8] ^ count[7:0] ^ CHK_KEY;
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return MAGIC_A;
      1:       return MAGIC_D;
      2:       return MAGIC_A2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (idle_en && $urandom_range(0, 99) < 10) begin
      byte_stream.valid <= 1'b0;
      @(posedge clk);
    end
    byte_stream.valid   <= 1'b1;
    byte_stream.rx_byte <= b;
    do @(posedge clk); while (!byte_stream.ready);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [15:0] count, input logic [BYTE_W-1:0] chk);
    send_byte(MAGIC_A);
    send_byte(MAGIC_D);
    send_byte(MAGIC_A2);
    send_byte(count[15:8]);
    send_byte(count[7:0]);
    send_byte(chk);
  endtask

  task automatic send_colors(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_good_frame();
    logic [15:0] count;
    count = 16'(cur_leds - 1);
    send_header(count, header_sum(count));
    if (cur_leds >= 1 && cur_leds <= MAX_LEDS) send_colors(cur_leds * BYTES_EACH_LED);
  endtask

  task automatic send_random_frame();
    int          pick;
    int          n;
    logic [15:0] count;
    pick  = $urandom_range(0, 99);
    count = 16'(cur_leds - 1);
    if (pick < 70) begin
      send_good_frame();
    end else if (pick < 80) begin
      send_header(count, header_sum(count) ^ 8'($urandom_range(1, 255)));
    end else if (pick < 90) begin
      count = 16'($urandom());
      send_header(count, header_sum(count));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(noise_byte());
    end
  endtask

  // Drop valid and hold until every due colour byte has transferred.
  task automatic wait_idle();
    byte_stream.valid <= 1'b0;
    do @(posedge clk); while (colors_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_leds(input int v);
    logic [APB_DATA_W-1:0] wdata;
    wait_idle();
    // upper bits are don't-care for the register
    wdata                = $urandom();
    wdata[LEDS_W-1:0]    = v[LEDS_W-1:0];
    apb_write({REG_EXPECTED_LEDS, 2'b00}, wdata);
    cur_leds = v;
    settings_used++;
  endtask

  initial begin
    int r;
    int v;
    int n;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    byte_stream.valid   <= 1'b0;
    byte_stream.rx_byte <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wrong second magic byte, then wrong third; the stray 'A' must not restart a header
    send_byte(MAGIC_A);
    send_byte(MAGIC_A);
    send_byte(MAGIC_D);
    send_byte(MAGIC_A);
    send_byte(MAGIC_D);
    send_byte(MAGIC_A);
    send_byte(MAGIC_D);
    send_header(16'd59, 8'h00);
    send_header(16'd58, header_sum(16'd58));
    send_header(16'hFFFF, header_sum(16'hFFFF));

    // full frame at the reset count while the colour side holds off
    hold_off_req = 1'b1;
    send_header(16'd59, header_sum(16'd59));
    send_byte(MAGIC_A);
    send_byte(MAGIC_D);
    send_byte(MAGIC_A2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_colors(cur_leds * BYTES_EACH_LED - 5);

    set_leds(1);
    repeat (6) send_random_frame();

    // count at the buffer limit: bad checksum, then a count one short
    set_leds(MAX_LEDS);
    send_header(16'(MAX_LEDS - 1), 8'h00);
    send_header(16'(MAX_LEDS - 2), header_sum(16'(MAX_LEDS - 2)));

    // long frame, no idling on either side
    set_leds(LONG_LEDS);
    idle_en = 1'b0;
    send_good_frame();
    idle_en = 1'b1;

    set_leds(0);
    send_header(16'hFFFF, header_sum(16'hFFFF));
    send_header(16'h0000, header_sum(16'h0000));
    set_leds(MAX_LEDS + 1);
    send_good_frame();
    set_leds(2047);
    send_good_frame();
    set_leds(3);
    repeat (4) send_random_frame();

    while (bytes_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        v = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_LEDS + 1, 2047);
      end else if (r < 4) begin
        v = $urandom_range(9, 60);
      end else begin
        v = $urandom_range(1, 8);
      end
      set_leds(v);
      if (settings_used % 7 == 0) idle_en = 1'b0;
      n = $urandom_range(3, 8);
      for (int k = 0; k < n && bytes_sent < TOTAL_ITEMS; k++) send_random_frame();
      idle_en = 1'b1;
    end
    wait_idle();

    $display("Covered %0d received bytes over %0d LED-count settings (0, 1, 1024, 1025, 2047",
             bytes_sent, settings_used);
    $display("and random ones), with %0d colour bytes checked; %0d mismatching transfers.",
             colors_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/lfhp_pkg.sv
src/lfhp_intf.sv
src/lfhp_cfg.sv
src/lfhp_parser.sv
src/lfhp_out_stage.sv
src/led_frame_header_parser_top.sv
sim/lfhp_color_checker.sv
sim/tb_led_frame_header_parser_top.sv
